// ----- hdl/esc_pkg.sv -----
package esc_pkg;

	// Request codes on the input beat.
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_ELEM = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_SIZE = 2'd1;
	localparam logic [1:0] CFG_USED = 2'd2;
	localparam logic [1:0] CFG_MIN  = 2'd3;

	localparam int NUM_CAND    = 64;
	localparam int CAND_BITS   = 6;
	localparam int MAX_ITEMSET = 4;
	localparam int POS_BITS    = 2;
	localparam int ID_BITS     = 20;
	localparam int PROB_BITS   = 17;
	localparam int FRAC_BITS   = 16;
	localparam int SUP_BITS    = 48;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;

	localparam logic [PROB_BITS-1:0] PROB_ONE = 17'h10000;
	localparam logic [SUP_BITS-1:0]  SUP_MAX  = {SUP_BITS{1'b1}};

	typedef struct packed {
		logic [1:0]           req_type;
		logic [CAND_BITS-1:0] cand_index;
		logic [POS_BITS-1:0]  item_pos;
		logic [ID_BITS-1:0]   item_id;
		logic [PROB_BITS-1:0] prob;
		logic                 last_in_transaction;
	} in_item_t;

	typedef struct packed {
		logic [CAND_BITS-1:0] read_index;
		logic [SUP_BITS-1:0]  support_value;
		logic                 is_frequent;
	} out_item_t;

	// Queued command from the front part to the back part.
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} cmd_t;

	typedef struct packed {
		logic                mode_uncertain;
		logic [2:0]          itemset_size;
		logic [6:0]          cand_in_use;
		logic [SUP_BITS-1:0] sup_thresh;
	} cfg_t;

	// Per-candidate match state.
	typedef struct packed {
		logic [2:0]           count;
		logic [PROB_BITS-1:0] prod;
		logic                 failed;
	} mstate_t;

endpackage

// ----- hdl/expected_support_counter.sv -----
// A read leaves the queue, then passes the READ and OUT states; its result is registered.
// A load is written while the back part is idle; a transaction element sweeps every candidate
// in use through the read, match, multiply and write states over the tables.
// A four-beat queue takes new beats while the back part works; the receiver cannot stall.
// Reset is asynchronous and active low; it empties the queue and clears all match
// and support state, so no clearing pass is needed.
module expected_support_counter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  esc_pkg::in_item_t  item,
	output logic               done,
	output esc_pkg::out_item_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	esc_pkg::cfg_t cfg_q;
	esc_pkg::cmd_t cmd;
	logic          pop;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_uncertain <= 1'b1;
			cfg_q.itemset_size   <= 3'd2;
			cfg_q.cand_in_use    <= '0;
			cfg_q.sup_thresh     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				esc_pkg::CFG_MODE: cfg_q.mode_uncertain <= cfg_data[0];
				esc_pkg::CFG_SIZE: cfg_q.itemset_size   <= cfg_data[2:0];
				esc_pkg::CFG_USED: cfg_q.cand_in_use    <= cfg_data[6:0];
				esc_pkg::CFG_MIN:  cfg_q.sup_thresh     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	esc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.pop    (pop),
		.cmd    (cmd)
	);

	esc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

// ----- hdl/esc_front.sv -----
module esc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  esc_pkg::in_item_t item,
	output logic             busy,
	input  logic             pop,
	output esc_pkg::cmd_t    cmd
);

	esc_pkg::in_item_t                  fifo_q [esc_pkg::QUEUE_DEPTH];
	logic [esc_pkg::QPTR_BITS-1:0]      wr_ptr_q;
	logic [esc_pkg::QPTR_BITS-1:0]      rd_ptr_q;
	logic [esc_pkg::QPTR_BITS:0]        count_q;
	logic                               push;
	logic                               do_pop;

	// Unused request codes are dropped at the door.
	assign busy   = (count_q == (esc_pkg::QPTR_BITS+1)'(esc_pkg::QUEUE_DEPTH));
	assign push   = start && !busy &&
		(item.req_type == esc_pkg::REQ_LOAD || item.req_type == esc_pkg::REQ_ELEM ||
		 item.req_type == esc_pkg::REQ_READ);
	assign do_pop = pop && (count_q != '0);

	assign cmd.valid = (count_q != '0);
	assign cmd.item  = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/esc_back.sv -----
module esc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  esc_pkg::cfg_t     cfg,
	input  esc_pkg::cmd_t     cmd,
	output logic              pop,
	output logic              done,
	output esc_pkg::out_item_t result
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_MATCH = 3'd2;
	localparam logic [2:0] ST_EXE   = 3'd3;
	localparam logic [2:0] ST_WB    = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	localparam int ITEM_ADDR_BITS = esc_pkg::CAND_BITS + esc_pkg::POS_BITS;

	logic [esc_pkg::ID_BITS-1:0]   items_mem [esc_pkg::NUM_CAND*esc_pkg::MAX_ITEMSET];
	esc_pkg::mstate_t              mst_mem   [esc_pkg::NUM_CAND];
	logic [esc_pkg::SUP_BITS-1:0]  sup_mem   [esc_pkg::NUM_CAND];
	logic [esc_pkg::NUM_CAND-1:0]  mvalid_q;
	logic [esc_pkg::NUM_CAND-1:0]  svalid_q;

	logic [2:0]                    state_q;
	esc_pkg::in_item_t             cur_q;
	logic [6:0]                    cand_q;
	logic [esc_pkg::CAND_BITS-1:0] rd_addr;
	esc_pkg::mstate_t              mst_rd_q;
	logic [esc_pkg::SUP_BITS-1:0]  sup_rd_q;
	logic                          mv_rd_q;
	logic                          sv_rd_q;
	logic [esc_pkg::ID_BITS-1:0]   want_q;
	esc_pkg::mstate_t              old_q;
	esc_pkg::mstate_t              new_q;
	esc_pkg::out_item_t            result_q;
	logic                          done_q;

	logic [6:0]                    used_eff;
	logic [2:0]                    size_eff;
	esc_pkg::mstate_t              old_st;
	esc_pkg::mstate_t              nxt_st;
	logic [esc_pkg::PROB_BITS-1:0] prob_sat;
	logic [2*esc_pkg::PROB_BITS-1:0] mult;
	logic                          active;
	logic [esc_pkg::SUP_BITS:0]    sum_wide;
	logic [esc_pkg::SUP_BITS-1:0]  sup_cur;
	logic                          add_sup;
	logic [6:0]                    cand_nxt;

	// Oversize registers fall back to the table limits.
	assign used_eff = (cfg.cand_in_use > 7'(esc_pkg::NUM_CAND)) ?
		7'(esc_pkg::NUM_CAND) : cfg.cand_in_use;
	assign size_eff = (cfg.itemset_size > 3'(esc_pkg::MAX_ITEMSET)) ?
		3'(esc_pkg::MAX_ITEMSET) : cfg.itemset_size;

	assign rd_addr  = (state_q == ST_READ) ? cur_q.cand_index : cand_q[esc_pkg::CAND_BITS-1:0];
	assign pop      = (state_q == ST_IDLE) && cmd.valid;
	assign cand_nxt = cand_q + 7'd1;

	// A slot whose state was cleared reads as count zero, product one, not failed.
	always_comb begin
		old_st = mst_rd_q;
		if (!mv_rd_q) begin
			old_st.count  = '0;
			old_st.prod   = esc_pkg::PROB_ONE;
			old_st.failed = 1'b0;
		end
	end

	// Merge step for one candidate against the current element.
	always_comb begin
		prob_sat = (cur_q.prob > esc_pkg::PROB_ONE) ? esc_pkg::PROB_ONE : cur_q.prob;
		mult     = 34'(old_q.prod) * 34'(prob_sat);
		active   = !old_q.failed && (old_q.count < size_eff);
		nxt_st   = old_q;
		if (active && want_q == cur_q.item_id) begin
			nxt_st.count = old_q.count + 3'd1;
			if (cfg.mode_uncertain) begin
				nxt_st.prod = mult[esc_pkg::FRAC_BITS +: esc_pkg::PROB_BITS];
			end
		end else if (active && want_q < cur_q.item_id) begin
			nxt_st.failed = 1'b1;
		end
	end

	// Saturating support update at the end of a transaction.
	always_comb begin
		sup_cur  = sv_rd_q ? sup_rd_q : '0;
		sum_wide = {1'b0, sup_cur} + 49'(new_q.prod);
		add_sup  = cur_q.last_in_transaction && !new_q.failed && (new_q.count >= size_eff);
	end

	// Memory reads, registered.
	always_ff @(posedge clk) begin
		mst_rd_q <= mst_mem[rd_addr];
		sup_rd_q <= sup_mem[rd_addr];
		want_q   <= items_mem[{cand_q[esc_pkg::CAND_BITS-1:0], old_st.count[esc_pkg::POS_BITS-1:0]}];
	end

	// Memory writes.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.valid && cmd.item.req_type == esc_pkg::REQ_LOAD) begin
			items_mem[ITEM_ADDR_BITS'({cmd.item.cand_index, cmd.item.item_pos})] <= cmd.item.item_id;
		end
		if (state_q == ST_WB) begin
			mst_mem[cand_q[esc_pkg::CAND_BITS-1:0]] <= new_q;
			if (add_sup) begin
				sup_mem[cand_q[esc_pkg::CAND_BITS-1:0]] <= sum_wide[esc_pkg::SUP_BITS] ?
					esc_pkg::SUP_MAX : sum_wide[esc_pkg::SUP_BITS-1:0];
			end
		end
	end

	// Payload registers of the sweep and the result.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= cmd.item;
		end
		if (state_q == ST_MATCH) begin
			old_q <= old_st;
		end
		if (state_q == ST_EXE) begin
			new_q <= nxt_st;
		end
		if (state_q == ST_OUT) begin
			result_q.read_index    <= cur_q.cand_index;
			result_q.support_value <= sup_cur;
			result_q.is_frequent   <= (sup_cur >= cfg.sup_thresh);
		end
	end

	// Sequencer and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cand_q   <= '0;
			mvalid_q <= '0;
			svalid_q <= '0;
			mv_rd_q  <= 1'b0;
			sv_rd_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q  <= (state_q == ST_OUT);
			mv_rd_q <= mvalid_q[rd_addr];
			sv_rd_q <= svalid_q[rd_addr];
			case (state_q)
				ST_IDLE: begin
					cand_q <= '0;
					if (cmd.valid) begin
						case (cmd.item.req_type)
							esc_pkg::REQ_LOAD: begin
								mvalid_q[cmd.item.cand_index] <= 1'b0;
								svalid_q[cmd.item.cand_index] <= 1'b0;
							end
							esc_pkg::REQ_ELEM: begin
								if (used_eff != '0) begin
									state_q <= ST_RD;
								end else if (cmd.item.last_in_transaction) begin
									mvalid_q <= '0;
								end
							end
							esc_pkg::REQ_READ: begin
								state_q <= ST_READ;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_MATCH;
				end
				ST_MATCH: begin
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (add_sup) begin
						svalid_q[cand_q[esc_pkg::CAND_BITS-1:0]] <= 1'b1;
					end
					cand_q <= cand_nxt;
					if (cand_nxt < used_eff) begin
						mvalid_q[cand_q[esc_pkg::CAND_BITS-1:0]] <= 1'b1;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_IDLE;
						// The last element clears the match state of every slot.
						if (cur_q.last_in_transaction) begin
							mvalid_q <= '0;
						end else begin
							mvalid_q[cand_q[esc_pkg::CAND_BITS-1:0]] <= 1'b1;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- bench/expected_support_counter_test.sv -----
`timescale 1ns / 1ps

module expected_support_counter_test;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 30;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	esc_pkg::in_item_t  item = '0;
	logic               done;
	esc_pkg::out_item_t result;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = esc_pkg::CFG_MODE;
	logic [47:0]        cfg_data = '0;

	expected_support_counter dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Shadow copy of the counter: tables, match state and registers.
	logic [esc_pkg::ID_BITS-1:0]   cand_ids [esc_pkg::NUM_CAND][esc_pkg::MAX_ITEMSET];
	logic [2:0]                    hit_count [esc_pkg::NUM_CAND];
	logic [esc_pkg::PROB_BITS-1:0] run_prod [esc_pkg::NUM_CAND];
	logic                          miss_flag [esc_pkg::NUM_CAND];
	logic [esc_pkg::SUP_BITS-1:0]  support [esc_pkg::NUM_CAND];
	logic                          sh_mode = 1'b1;
	logic [2:0]                    sh_size = 3'd2;
	logic [6:0]                    sh_used = 7'd0;
	logic [esc_pkg::SUP_BITS-1:0]  sh_min = '0;

	// Slots whose four positions have all been loaded.
	bit                   slot_loaded [esc_pkg::NUM_CAND];

	esc_pkg::in_item_t  pending_beats [$];
	esc_pkg::out_item_t support_reports [$];

	int n_accepted = 0;
	int n_checked = 0;
	int n_txn = 0;
	int n_mismatch = 0;
	int n_cfg = 0;
	int quiet_cycles = 0;

	initial begin
		for (int c = 0; c < esc_pkg::NUM_CAND; c++) begin
			hit_count[c] = '0;
			run_prod[c] = esc_pkg::PROB_ONE;
			miss_flag[c] = 1'b0;
			support[c] = '0;
			slot_loaded[c] = 0;
			for (int p = 0; p < esc_pkg::MAX_ITEMSET; p++)
				cand_ids[c][p] = '0;
		end
	end

	function automatic void clear_match(int c);
		hit_count[c] = '0;
		run_prod[c] = esc_pkg::PROB_ONE;
		miss_flag[c] = 1'b0;
	endfunction

	// Merge one transaction element into every candidate in use.
	function automatic void merge_element(esc_pkg::in_item_t b);
		int                            size;
		int                            used;
		logic [esc_pkg::PROB_BITS-1:0] p;
		logic [33:0]                   prod;
		logic [esc_pkg::SUP_BITS:0]    sum;
		logic [esc_pkg::ID_BITS-1:0]   want;
		size = (sh_size > esc_pkg::MAX_ITEMSET) ? esc_pkg::MAX_ITEMSET : sh_size;
		used = (sh_used > esc_pkg::NUM_CAND) ? esc_pkg::NUM_CAND : sh_used;
		p = (b.prob > esc_pkg::PROB_ONE) ? esc_pkg::PROB_ONE : b.prob;
		for (int c = 0; c < used; c++) begin
			if (!miss_flag[c] && hit_count[c] < size) begin
				want = cand_ids[c][hit_count[c]];
				if (want == b.item_id) begin
					if (sh_mode) begin
						prod = run_prod[c] * p;
						run_prod[c] = prod[esc_pkg::FRAC_BITS +: esc_pkg::PROB_BITS];
					end
					hit_count[c]++;
				end else if (want < b.item_id) begin
					miss_flag[c] = 1'b1;
				end
			end
			if (b.last_in_transaction && !miss_flag[c] && hit_count[c] >= size) begin
				sum = support[c] + run_prod[c];
				support[c] = sum[esc_pkg::SUP_BITS] ? esc_pkg::SUP_MAX :
					sum[esc_pkg::SUP_BITS-1:0];
			end
		end
		if (b.last_in_transaction) begin
			n_txn++;
			for (int c = 0; c < esc_pkg::NUM_CAND; c++)
				clear_match(c);
		end
	endfunction

	// Apply one accepted input beat; reads queue the expected support report.
	function automatic void predict_support(esc_pkg::in_item_t b);
		esc_pkg::out_item_t r;
		case (b.req_type)
			esc_pkg::REQ_LOAD: begin
				cand_ids[b.cand_index][b.item_pos] = b.item_id;
				support[b.cand_index] = '0;
				clear_match(b.cand_index);
			end
			esc_pkg::REQ_ELEM: begin
				merge_element(b);
			end
			esc_pkg::REQ_READ: begin
				r.read_index = b.cand_index;
				r.support_value = support[b.cand_index];
				r.is_frequent = (support[b.cand_index] >= sh_min);
				support_reports.push_back(r);
			end
			default: begin
			end
		endcase
	endfunction

	// Driver: presents pending beats, idling at random outside a quiet stretch.
	always @(posedge clk) begin
		bit hold;
		hold = !(n_accepted >= 200 && n_accepted < 330) && ($urandom_range(0, 99) < 31);
		if (arst_n) begin
			if (start && !busy) begin
				predict_support(item);
				n_accepted++;
			end
			if (!start || !busy) begin
				if (pending_beats.size() > 0 && !hold) begin
					start <= 1'b1;
					item <= pending_beats.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: each strobed result against the oldest expected report.
	always @(posedge clk) begin
		esc_pkg::out_item_t e;
		if (arst_n && done) begin
			if (support_reports.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result: index %0d support %0h frequent %0b",
						result.read_index, result.support_value, result.is_frequent);
			end else begin
				e = support_reports.pop_front();
				n_checked++;
				if (result.read_index !== e.read_index
						|| result.support_value !== e.support_value
						|| result.is_frequent !== e.is_frequent) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: expected %0d/%0h/%0b, got %0d/%0h/%0b",
							e.read_index, e.support_value, e.is_frequent,
							result.read_index, result.support_value, result.is_frequent);
				end
			end
		end
	end

	// Watchdog: too long without any beat moving ends the run.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", quiet_cycles);
			$display("** expected_support_counter: FAILED **");
			$finish;
		end
	end

	function automatic esc_pkg::in_item_t make_beat(logic [1:0] req, int slot, int pos,
			int unsigned id, int unsigned p, int unsigned last);
		esc_pkg::in_item_t b;
		b.req_type = req;
		b.cand_index = slot[esc_pkg::CAND_BITS-1:0];
		b.item_pos = pos[esc_pkg::POS_BITS-1:0];
		b.item_id = id[esc_pkg::ID_BITS-1:0];
		b.prob = p[esc_pkg::PROB_BITS-1:0];
		b.last_in_transaction = last[0];
		return b;
	endfunction

	// Load a whole candidate with ascending ids from a small alphabet.
	task automatic load_candidate(int slot);
		int id;
		id = $urandom_range(0, 4);
		for (int p = 0; p < esc_pkg::MAX_ITEMSET; p++) begin
			pending_beats.push_back(make_beat(esc_pkg::REQ_LOAD, slot, p, id, $urandom, 1'b0));
			id += $urandom_range(1, 4);
		end
		slot_loaded[slot] = 1;
	endtask

	function automatic logic [esc_pkg::PROB_BITS-1:0] pick_prob();
		int          r;
		int unsigned v;
		r = $urandom_range(0, 99);
		if (r < 35)
			v = esc_pkg::PROB_ONE;
		else if (r < 90)
			v = $urandom_range(0, 65536);
		else
			v = $urandom_range(65537, 131071);
		return v[esc_pkg::PROB_BITS-1:0];
	endfunction

	// One transaction: ascending ids, the last one marked; sometimes broken.
	task automatic queue_transaction();
		int n;
		int id;
		bit broken;
		n = $urandom_range(1, 7);
		id = $urandom_range(0, 3);
		broken = ($urandom_range(0, 99) < 10);
		for (int k = 0; k < n; k++) begin
			pending_beats.push_back(make_beat(esc_pkg::REQ_ELEM, $urandom, $urandom,
				broken ? $urandom_range(0, 24) : id, pick_prob(),
				(k == n - 1) && !(broken && $urandom_range(0, 1))));
			id += $urandom_range(1, 3);
		end
	endtask

	// Wait until every beat is taken and every report has come back.
	task automatic drain();
		wait (pending_beats.size() == 0 && !start && support_reports.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_registers(logic mode, logic [2:0] size, logic [6:0] used,
			logic [47:0] minv);
		logic [47:0] vals [4];
		logic [1:0]  idx [4];
		vals = '{48'(mode), 48'(size), 48'(used), minv};
		idx = '{esc_pkg::CFG_MODE, esc_pkg::CFG_SIZE, esc_pkg::CFG_USED, esc_pkg::CFG_MIN};
		@(posedge clk);
		for (int r = 0; r < 4; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[r];
			cfg_data <= vals[r];
			do @(posedge clk); while (!cfg_ready);
			n_cfg++;
		end
		cfg_valid <= 1'b0;
		sh_mode = mode;
		sh_size = size;
		sh_used = used;
		sh_min = minv;
	endtask

	// One phase of random traffic under one register setting.
	task automatic run_phase(logic mode, logic [2:0] size, logic [6:0] used,
			logic [47:0] minv, int beats);
		int lim;
		int slot;
		int r;
		drain();
		write_registers(mode, size, used, minv);
		lim = (used > esc_pkg::NUM_CAND) ? esc_pkg::NUM_CAND : used;
		for (int c = 0; c < lim; c++)
			if (!slot_loaded[c])
				load_candidate(c);
		while (beats > 0) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				queue_transaction();
			end else if (r < 85) begin
				pending_beats.push_back(make_beat(esc_pkg::REQ_READ,
					$urandom_range(0, lim + 2), $urandom, $urandom, $urandom, $urandom));
			end else if (r < 95) begin
				slot = $urandom_range(0, esc_pkg::NUM_CAND - 1);
				if (slot_loaded[slot] || slot >= lim)
					pending_beats.push_back(make_beat(esc_pkg::REQ_LOAD, slot, $urandom,
						$urandom_range(0, 24), $urandom, $urandom));
			end else begin
				pending_beats.push_back(make_beat(REQ_UNUSED, $urandom, $urandom,
					$urandom, $urandom, $urandom));
			end
			beats--;
		end
		for (int c = 0; c < lim; c++)
			pending_beats.push_back(make_beat(esc_pkg::REQ_READ, c, 0, 0, 0, 1'b0));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme ids and probabilities, unused code, a transaction.
		pending_beats.push_back(make_beat(esc_pkg::REQ_LOAD, 0, 0, 20'd0, 0, 0));
		pending_beats.push_back(make_beat(esc_pkg::REQ_LOAD, 0, 1, 20'd5, 0, 0));
		pending_beats.push_back(make_beat(esc_pkg::REQ_LOAD, 0, 2, 20'd9, 0, 0));
		pending_beats.push_back(make_beat(esc_pkg::REQ_LOAD, 0, 3, 20'hFFFFF, 0, 0));
		pending_beats.push_back(make_beat(esc_pkg::REQ_LOAD, 63, 0, 20'd3, 0, 0));
		pending_beats.push_back(make_beat(esc_pkg::REQ_LOAD, 63, 1, 20'd5, 0, 0));
		pending_beats.push_back(make_beat(esc_pkg::REQ_LOAD, 63, 2, 20'd7, 0, 0));
		pending_beats.push_back(make_beat(esc_pkg::REQ_LOAD, 63, 3, 20'd8, 0, 0));
		pending_beats.push_back(make_beat(REQ_UNUSED, 63, 3, 20'hFFFFF, 17'h1FFFF, 1'b1));
		pending_beats.push_back(make_beat(esc_pkg::REQ_READ, 63, 3, 20'hFFFFF, 17'h1FFFF,
			1'b1));
		slot_loaded[0] = 1;
		slot_loaded[63] = 1;
		for (int c = 1; c < 63; c++)
			load_candidate(c);
		drain();
		write_registers(1'b1, 3'd4, 7'd64, 48'd1);
		pending_beats.push_back(make_beat(esc_pkg::REQ_ELEM, 0, 0, 20'd0, esc_pkg::PROB_ONE,
			1'b0));
		pending_beats.push_back(make_beat(esc_pkg::REQ_ELEM, 0, 0, 20'd3, 17'h1FFFF, 1'b0));
		pending_beats.push_back(make_beat(esc_pkg::REQ_ELEM, 0, 0, 20'd5, 17'h08000, 1'b0));
		pending_beats.push_back(make_beat(esc_pkg::REQ_ELEM, 0, 0, 20'd9, 17'h0C000, 1'b0));
		pending_beats.push_back(make_beat(esc_pkg::REQ_ELEM, 0, 0, 20'hFFFFF, 17'h0FFFF,
			1'b1));
		pending_beats.push_back(make_beat(esc_pkg::REQ_ELEM, 0, 0, 20'd0, 17'd0, 1'b1));
		pending_beats.push_back(make_beat(esc_pkg::REQ_READ, 0, 0, 0, 0, 1'b0));
		pending_beats.push_back(make_beat(esc_pkg::REQ_READ, 63, 0, 0, 0, 1'b0));

		// Random phases over a spread of register settings, extremes included.
		run_phase(1'b1, 3'd1, 7'd4, 48'h0, 6);
		run_phase(1'b0, 3'd4, 7'd8, 48'h2_0000, 6);
		run_phase(1'b1, 3'd0, 7'd3, {32'h0, 16'($urandom)}, 4);
		run_phase(1'b1, 3'd7, 7'd100, 48'hFFFF_FFFF_FFFF, 4);
		run_phase(1'b0, 3'd2, 7'd5, 48'h1_0000, 6);
		run_phase(1'b1, 3'd3, 7'd64, {16'h0, 32'($urandom_range(0, 300000))}, 4);
		run_phase(1'b1, 3'd2, 7'd0, 48'h0, 3);
		run_phase(1'b1, 3'd2, 7'd12, 48'h8000, 8);
		run_phase(1'b0, 3'd1, 7'd2, {16'($urandom), 32'($urandom)}, 6);
		drain();

		$display("covered %0d beats, %0d transactions, %0d support reads checked",
			n_accepted, n_txn, n_checked);
		$display("register writes: %0d, mismatches: %0d", n_cfg, n_mismatch);
		if (n_mismatch == 0 && support_reports.size() == 0)
			$display("** expected_support_counter: PASSED **");
		else
			$display("** expected_support_counter: FAILED **");
		$finish;
	end

endmodule
